// ===== src/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
`default_nettype none
package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int ITEM_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_PUSH_R = 2'd1,
      ACT_POP_L  = 2'd2,
      ACT_POP_R  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      action_type            action;
      logic [ITEM_WIDTH-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [ITEM_WIDTH-1:0] popped_value;
      status_type            status;
      logic [CNT_W-1:0]      entry_count;
      logic                  is_empty;
      logic [ITEM_WIDTH-1:0] left_entry;
      logic [ITEM_WIDTH-1:0] right_entry;
   } rsp_type;

   // Shift commands broadcast to every cell of the chain
   typedef struct packed {
      logic shift_up;
      logic shift_down;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== src/deq_cell.sv =====
// One storage cell of the queue chain: hold, take from lower or upper neighbor.
`default_nettype none
module deq_cell (
   input  wire logic                          clock,
   input  wire deq_pkg::cell_ctl_type         ctl,
   input  wire logic [deq_pkg::ITEM_WIDTH-1:0] lower_data,
   input  wire logic [deq_pkg::ITEM_WIDTH-1:0] upper_data,
   output logic      [deq_pkg::ITEM_WIDTH-1:0] data
);
   import deq_pkg::*;

   logic [ITEM_WIDTH-1:0] data_ff;
   logic [ITEM_WIDTH-1:0] data_in;

   // Pick the next value from the shift command
   always_comb begin
      data_in = data_ff;
      if (ctl.shift_up) begin
         data_in = lower_data;
      end else if (ctl.shift_down) begin
         data_in = upper_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
`default_nettype wire

// ===== src/deq_chain.sv =====
// Row of queue cells; rightmost entry sits in cell 0, leftmost in cell count-1.
`default_nettype none
module deq_chain (
   input  wire logic                           clock,
   input  wire deq_pkg::cell_ctl_type          ctl,
   input  wire logic [deq_pkg::ITEM_WIDTH-1:0] push_value,
   input  wire logic [deq_pkg::CNT_W-1:0]      count,
   output logic      [deq_pkg::ITEM_WIDTH-1:0] left_tap,
   output logic      [deq_pkg::ITEM_WIDTH-1:0] right_tap
);
   import deq_pkg::*;

   logic [ITEM_WIDTH-1:0] cell_data [DEPTH];
   logic [CNT_W-1:0]      last_pos;
   logic [IDX_W-1:0]      left_idx;

   // Build the chain; cell 0 takes the pushed value, the top cell refills itself
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ITEM_WIDTH-1:0] lower;
      logic [ITEM_WIDTH-1:0] upper;
      if (i == 0) begin : g_first
         assign lower = push_value;
      end else begin : g_mid_lo
         assign lower = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign upper = cell_data[i];
      end else begin : g_mid_hi
         assign upper = cell_data[i+1];
      end
      deq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .lower_data (lower),
         .upper_data (upper),
         .data       (cell_data[i])
      );
   end

   // Tap the leftmost live entry; meaningful only while count is nonzero
   assign last_pos  = count - CNT_W'(1);
   assign left_idx  = last_pos[IDX_W-1:0];
   assign left_tap  = cell_data[left_idx];
   assign right_tap = cell_data[0];

endmodule
`default_nettype wire

// ===== src/double_ended_queue.sv =====
// Double-ended queue top level: request decode, count tracking, result register.
//
// Usage:
//  - req channel carries one transaction per queue action (none, push right,
//    pop left, pop right) with the value to push. It is accepted when
//    req_valid is high and req_stall is low.
//  - rsp channel returns exactly one transaction per request: popped value,
//    status, entry count after the action, empty flag, and the leftmost and
//    rightmost entries after the action.
//  - The cell chain shifts and the count updates at the clock edge that
//    accepts a request; the result is then loaded into the rsp register from
//    the chain end taps once that register is free. A new request is not
//    accepted until the result of the previous one has been loaded.
//  - Push into a full queue or pop from an empty one reports a status code,
//    returns zero as popped value and leaves the contents unchanged.
//  - When the receiver stalls, the result holds in the rsp register; one
//    further request is still accepted and waits finished in the chain
//    until the result register frees.
//  - Reset empties the queue and drops any pending transaction. Cell
//    contents are not cleared; they are never shown while not live.
`default_nettype none
module double_ended_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire deq_pkg::req_type req,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output deq_pkg::rsp_type      rsp
);
   import deq_pkg::*;

   logic                  busy_ff;
   logic                  busy_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [ITEM_WIDTH-1:0] popped_ff;
   logic [ITEM_WIDTH-1:0] popped_in;
   status_type            status_ff;
   status_type            status_in;

   logic                  req_accept;
   logic                  rsp_free;
   logic                  finish;
   logic                  now_empty;
   cell_ctl_type          ctl;
   logic [ITEM_WIDTH-1:0] left_tap;
   logic [ITEM_WIDTH-1:0] right_tap;

   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign finish     = busy_ff && rsp_free;

   // Decode the action into shift commands, new count and status
   always_comb begin
      ctl       = '0;
      count_in  = count_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      if (req_accept) begin
         popped_in = '0;
         status_in = ST_OK;
         unique case (req.action)
            ACT_PUSH_R: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.shift_up = 1'b1;
                  count_in     = count_ff + CNT_W'(1);
               end
            end
            ACT_POP_L: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  popped_in = left_tap;
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            ACT_POP_R: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  popped_in      = right_tap;
                  ctl.shift_down = 1'b1;
                  count_in       = count_ff - CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   deq_chain u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .push_value (req.item_value),
      .count      (count_ff),
      .left_tap   (left_tap),
      .right_tap  (right_tap)
   );

   // Load the result register from the settled chain, or drain it
   assign now_empty = (count_ff == '0);

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         busy_in              = 1'b0;
         rsp_valid_in         = 1'b1;
         rsp_in.popped_value  = popped_ff;
         rsp_in.status        = status_ff;
         rsp_in.entry_count   = count_ff;
         rsp_in.is_empty      = now_empty;
         rsp_in.left_entry    = now_empty ? '0 : left_tap;
         rsp_in.right_entry   = now_empty ? '0 : right_tap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Count never exceeds the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   // An accepted request occupies the sequencer on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> busy_ff)
      else $error("accepted request not in flight");

   // Failed actions return zero and leave the count unchanged
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      finish && status_ff != ST_OK |-> popped_ff == '0 && count_ff == $past(count_ff))
      else $error("failed action changed state or returned data");

   // Empty flag agrees with the reported count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.is_empty == (rsp_ff.entry_count == '0))
      else $error("empty flag disagrees with count");

endmodule
`default_nettype wire
